[hw/rtl/bwt_pkg.sv]
// shared constants, types and state encodings for the block sorting transform
// no dependencies; imported by bwt_suffix_cmp and bwt_block_encoder
package bwt_pkg;

  localparam int BLOCK_MAX = 64;
  localparam int ADDR_W    = $clog2(BLOCK_MAX);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int BYTE_W    = 8;

  typedef logic [ADDR_W-1:0] pos_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_RD,
    C_EV
  } cmp_state_t;

  typedef enum logic [2:0] {
    S_FILL,
    S_CMP_START,
    S_CMP_WAIT,
    S_STORE,
    S_OUT_ADDR,
    S_OUT_POS,
    S_OUT_TEXT,
    S_OUT_HOLD
  } seq_state_t;

  typedef struct packed {
    logic start;
    pos_t a;
    pos_t b;
    cnt_t n;
  } cmp_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic less;
  } cmp_rsp_t;

endpackage

[hw/rtl/bwt_ram.sv]
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module bwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/bwt_suffix_cmp.sv]
// suffix compare unit: walks two suffixes one byte pair per step
// depends on bwt_pkg; reads the text through two external ram read ports
module bwt_suffix_cmp
  import bwt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cmp_req_t req,
  output cmp_rsp_t rsp,
  output pos_t     rd_a,
  output pos_t     rd_b,
  input  byte_t    data_a,
  input  byte_t    data_b
);

  cmp_state_t state_r, state_nxt;
  cnt_t       pa_r, pa_nxt;
  cnt_t       pb_r, pb_nxt;
  cnt_t       n_r, n_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    pa_r <= pa_nxt;
    pb_r <= pb_nxt;
    n_r  <= n_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    pa_nxt    = pa_r;
    pb_nxt    = pb_r;
    n_nxt     = n_r;
    rsp.busy  = (state_r != C_IDLE);
    rsp.done  = 1'b0;
    rsp.less  = 1'b0;
    rd_a      = pa_r[ADDR_W-1:0];
    rd_b      = pb_r[ADDR_W-1:0];
    unique case (state_r)
      C_IDLE: begin
        if (req.start) begin
          pa_nxt    = {1'b0, req.a};
          pb_nxt    = {1'b0, req.b};
          n_nxt     = req.n;
          state_nxt = C_RD;
        end
      end
      C_RD: begin
        // running off the block end makes that suffix the smaller one
        if (pa_r >= n_r || pb_r >= n_r) begin
          rsp.done  = 1'b1;
          rsp.less  = (pa_r >= n_r);
          state_nxt = C_IDLE;
        end else begin
          state_nxt = C_EV;
        end
      end
      C_EV: begin
        if (data_a != data_b) begin
          rsp.done  = 1'b1;
          rsp.less  = (data_a < data_b);
          state_nxt = C_IDLE;
        end else begin
          pa_nxt    = pa_r + cnt_t'(1);
          pb_nxt    = pb_r + cnt_t'(1);
          state_nxt = C_RD;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

endmodule

[hw/rtl/bwt_block_encoder.sv]
// Block sorting transform encoder. Bytes are taken one per cycle while in_ready is high, up to
// 64 per block; a byte with in_block_end set, or the 64th byte, closes the block and in_ready
// drops until every result of that block has been transferred. Each suffix is ranked by
// comparing it with every other suffix in one shared compare unit that reads the text through
// two ram read ports, one byte pair per step until the bytes differ or a suffix runs out. Each
// result then reads the rank table, then the text at the cyclic predecessor of that position,
// and is held on the output until out_ready takes it. No clearing pass is needed after reset.
// depends on bwt_pkg, bwt_ram and bwt_suffix_cmp
module bwt_block_encoder
  import bwt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  byte_t in_data_byte,
  input  logic  in_block_end,
  output logic  out_valid,
  input  logic  out_ready,
  output byte_t out_byte,
  output logic  out_last
);

  seq_state_t state_r, state_nxt;
  cnt_t       fill_r, fill_nxt;
  cnt_t       n_r, n_nxt;
  cnt_t       i_r, i_nxt;
  cnt_t       j_r, j_nxt;
  pos_t       rank_r, rank_nxt;
  cnt_t       k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  byte_t      out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  cmp_req_t cmp_req;
  cmp_rsp_t cmp_rsp;
  pos_t     cmp_rd_a, cmp_rd_b;

  logic  text_we;
  pos_t  text_raddr_a;
  byte_t text_rdata_a, text_rdata_b;
  logic  sorted_we;
  pos_t  sorted_rdata;
  pos_t  prev_pos;
  logic  in_xfer;

  assign in_xfer = in_valid && in_ready;
  assign text_we = in_xfer;

  bwt_ram #(.WIDTH(BYTE_W), .DEPTH(BLOCK_MAX)) u_text_a (
    .clk  (clk),
    .we   (text_we),
    .waddr(fill_r[ADDR_W-1:0]),
    .wdata(in_data_byte),
    .raddr(text_raddr_a),
    .rdata(text_rdata_a)
  );

  bwt_ram #(.WIDTH(BYTE_W), .DEPTH(BLOCK_MAX)) u_text_b (
    .clk  (clk),
    .we   (text_we),
    .waddr(fill_r[ADDR_W-1:0]),
    .wdata(in_data_byte),
    .raddr(cmp_rd_b),
    .rdata(text_rdata_b)
  );

  bwt_ram #(.WIDTH(ADDR_W), .DEPTH(BLOCK_MAX)) u_sorted (
    .clk  (clk),
    .we   (sorted_we),
    .waddr(rank_r),
    .wdata(i_r[ADDR_W-1:0]),
    .raddr(k_r[ADDR_W-1:0]),
    .rdata(sorted_rdata)
  );

  bwt_suffix_cmp u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cmp_req),
    .rsp   (cmp_rsp),
    .rd_a  (cmp_rd_a),
    .rd_b  (cmp_rd_b),
    .data_a(text_rdata_a),
    .data_b(text_rdata_b)
  );

  // cyclic predecessor of the sorted position
  assign prev_pos = (sorted_rdata == '0) ? pos_t'(n_r - cnt_t'(1)) : (sorted_rdata - pos_t'(1));
  assign text_raddr_a = (state_r == S_OUT_POS) ? prev_pos : cmp_rd_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    rank_r     <= rank_nxt;
    k_r        <= k_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rank_nxt      = rank_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    in_ready      = 1'b0;
    sorted_we     = 1'b0;
    cmp_req.start = 1'b0;
    cmp_req.a     = j_r[ADDR_W-1:0];
    cmp_req.b     = i_r[ADDR_W-1:0];
    cmp_req.n     = n_r;
    unique case (state_r)
      S_FILL: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_block_end || (fill_r + cnt_t'(1)) == cnt_t'(BLOCK_MAX)) begin
            n_nxt     = fill_r + cnt_t'(1);
            fill_nxt  = '0;
            i_nxt     = '0;
            j_nxt     = '0;
            rank_nxt  = '0;
            state_nxt = S_CMP_START;
          end else begin
            fill_nxt = fill_r + cnt_t'(1);
          end
        end
      end
      S_CMP_START: begin
        if (j_r == n_r) begin
          state_nxt = S_STORE;
        end else if (j_r == i_r) begin
          j_nxt = j_r + cnt_t'(1);
        end else begin
          cmp_req.start = 1'b1;
          state_nxt     = S_CMP_WAIT;
        end
      end
      S_CMP_WAIT: begin
        if (cmp_rsp.done) begin
          if (cmp_rsp.less) begin
            rank_nxt = rank_r + pos_t'(1);
          end
          j_nxt     = j_r + cnt_t'(1);
          state_nxt = S_CMP_START;
        end
      end
      S_STORE: begin
        sorted_we = 1'b1;
        i_nxt     = i_r + cnt_t'(1);
        j_nxt     = '0;
        rank_nxt  = '0;
        if ((i_r + cnt_t'(1)) == n_r) begin
          k_nxt     = '0;
          state_nxt = S_OUT_ADDR;
        end else begin
          state_nxt = S_CMP_START;
        end
      end
      S_OUT_ADDR: begin
        state_nxt = S_OUT_POS;
      end
      S_OUT_POS: begin
        state_nxt = S_OUT_TEXT;
      end
      S_OUT_TEXT: begin
        out_byte_nxt  = text_rdata_a;
        out_last_nxt  = ((k_r + cnt_t'(1)) == n_r);
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT_HOLD;
      end
      S_OUT_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          k_nxt         = k_r + cnt_t'(1);
          state_nxt     = out_last_r ? S_FILL : S_OUT_ADDR;
        end
      end
      default: state_nxt = S_FILL;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // input side and result side never open together
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and result side open together");

  // the compare unit is only started when free
  a_cmp_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_req.start |-> !cmp_rsp.busy)
    else $error("compare started while busy");

  // a rank always lies inside the block
  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STORE) |-> ({1'b0, rank_r} < n_r))
    else $error("rank outside block");

  // the last result of a block sends the sequencer back to collecting
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> (state_r == S_FILL && fill_r == '0))
    else $error("block not closed after last result");

endmodule

[dv/tb.sv]
// testbench for bwt_block_encoder: byte blocks in, sorted-suffix transform bytes out
// a directed table comes first, then random blocks checked against an in-bench suffix sort
// depends on bwt_pkg and the bwt_block_encoder rtl
module tb;
  import bwt_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  fin;
    logic  typed;
    byte_t want;
  } dir_row_t;

  typedef struct packed {
    byte_t b;
    logic  last;
  } bwt_out_t;

  typedef enum int {TXT_RANDOM, TXT_TWO_SYM, TXT_RUN, TXT_PERIODIC} text_kind_t;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam int RAND_ITEMS = 300;

  localparam dir_row_t DIR_ROWS [21] = '{
    '{8'h01, 1'b1, 1'b1, 8'h01},
    '{8'hFF, 1'b1, 1'b1, 8'hFF},
    '{8'h00, 1'b1, 1'b1, 8'h00},
    '{8'h62, 1'b0, 1'b0, 8'h00},
    '{8'h61, 1'b0, 1'b0, 8'h00},
    '{8'h6E, 1'b0, 1'b0, 8'h00},
    '{8'h61, 1'b0, 1'b0, 8'h00},
    '{8'h6E, 1'b0, 1'b0, 8'h00},
    '{8'h61, 1'b1, 1'b0, 8'h00},
    '{8'hFF, 1'b0, 1'b0, 8'h00},
    '{8'h01, 1'b1, 1'b0, 8'h00},
    '{8'h00, 1'b0, 1'b0, 8'h00},
    '{8'h01, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b1, 1'b0, 8'h00},
    '{8'h55, 1'b0, 1'b0, 8'h00},
    '{8'h55, 1'b0, 1'b0, 8'h00},
    '{8'h55, 1'b0, 1'b0, 8'h00},
    '{8'h55, 1'b1, 1'b0, 8'h00},
    '{8'hAA, 1'b1, 1'b1, 8'hAA},
    '{8'h80, 1'b0, 1'b0, 8'h00},
    '{8'h7F, 1'b1, 1'b0, 8'h00}
  };

  logic  clk;
  logic  rst_n        = 1'b0;
  logic  in_valid     = 1'b0;
  logic  in_ready;
  byte_t in_data_byte = '0;
  logic  in_block_end = 1'b0;
  logic  out_valid;
  logic  out_ready    = 1'b0;
  byte_t out_byte;
  logic  out_last;

  byte_t    text_buf [BLOCK_MAX];
  int       fill_len;
  bwt_out_t bwt_expect_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_count      = 0;
  int bytes_taken    = 0;
  int blocks_closed  = 0;
  int full_closed    = 0;
  int bytes_checked  = 0;

  bwt_block_encoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_block_end (in_block_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit suffix_precedes(int a, int b, int n);
    while (a < n && b < n) begin
      if (text_buf[a] != text_buf[b]) return text_buf[a] < text_buf[b];
      a++;
      b++;
    end
    // the shorter suffix ran out first and sorts lower
    return a >= n && b < n;
  endfunction

  function automatic void transform_block(int n);
    int       order [BLOCK_MAX];
    int       i;
    int       j;
    int       p;
    bwt_out_t r;
    for (i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && suffix_precedes(i, order[j-1], n)) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (i = 0; i < n; i++) begin
      p = order[i];
      r.b = text_buf[(p == 0) ? n - 1 : p - 1];
      r.last = (i == n - 1);
      bwt_expect_q.push_back(r);
    end
  endfunction

  function automatic void absorb_byte(byte_t bt, logic fin);
    text_buf[fill_len] = bt;
    fill_len++;
    bytes_taken++;
    if (fin || fill_len == BLOCK_MAX) begin
      if (fill_len == BLOCK_MAX) full_closed++;
      transform_block(fill_len);
      blocks_closed++;
      fill_len = 0;
    end
  endfunction

  function automatic void check_result(byte_t bt, logic lst);
    bwt_out_t w;
    if (bwt_expect_q.size() == 0) begin
      $error("out_byte: expected no transfer, got %0h", bt);
      err_count++;
    end else begin
      w = bwt_expect_q.pop_front();
      if (w.b != bt) begin
        $error("out_byte: expected %0h, got %0h", w.b, bt);
        err_count++;
      end
      if (w.last != lst) begin
        $error("out_last: expected %0b, got %0b", w.last, lst);
        err_count++;
      end
      bytes_checked++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) absorb_byte(in_data_byte, in_block_end);
    if (rst_n && out_valid && out_ready) check_result(out_byte, out_last);
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_byte(input byte_t bt, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= bt;
    in_block_end <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_idle(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct  = 70;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct  = 0;
        recv_stall_pct = 70;
      end
      default: begin
        send_idle_pct  = 30;
        recv_stall_pct = 30;
      end
    endcase
  endtask

  initial begin
    int         r;
    int         i;
    int         rand_items;
    int         len;
    int         period;
    int         full_forced;
    logic       flag_end;
    text_kind_t kind;
    byte_t      sym_a;
    byte_t      sym_b;
    byte_t      bt;
    bwt_out_t   tail;

    fill_len    = 0;
    rand_items  = 0;
    full_forced = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, single-byte blocks carry a typed expectation
    set_idle(IDLE_NONE);
    for (r = 0; r < 21; r++) begin
      send_byte(DIR_ROWS[r].data, DIR_ROWS[r].fin);
      if (DIR_ROWS[r].typed) begin
        tail = (bwt_expect_q.size() != 0) ? bwt_expect_q[$] : '0;
        if (bwt_expect_q.size() == 0 || tail.b != DIR_ROWS[r].want || !tail.last) begin
          $error("out_byte: expected %0h, predicted %0h", DIR_ROWS[r].want, tail.b);
          err_count++;
        end
      end
    end

    // random blocks, mostly short, two at full size
    while (rand_items < RAND_ITEMS) begin
      set_idle(idle_mode_t'(rand_items * 4 / RAND_ITEMS));
      flag_end = 1'b1;
      if ((full_forced == 0 && rand_items >= 100) || (full_forced == 1 && rand_items >= 200)) begin
        len  = BLOCK_MAX;
        kind = (full_forced == 0) ? TXT_RANDOM : TXT_TWO_SYM;
        // first full block closes on saturation alone
        flag_end = (full_forced == 1);
        full_forced++;
      end else begin
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        kind = text_kind_t'($urandom_range(0, 3));
      end
      sym_a  = byte_t'($urandom_range(0, 255));
      sym_b  = byte_t'($urandom_range(0, 255));
      period = $urandom_range(2, 4);
      for (i = 0; i < len; i++) begin
        case (kind)
          TXT_RANDOM:   bt = byte_t'($urandom_range(0, 255));
          TXT_TWO_SYM:  bt = $urandom_range(0, 1) ? sym_a : sym_b;
          TXT_RUN:      bt = sym_a;
          default:      bt = (i % period == 0) ? sym_a : sym_b;
        endcase
        send_byte(bt, flag_end && (i == len - 1));
        rand_items++;
      end
    end
    in_valid <= 1'b0;

    while (bwt_expect_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d bytes taken in %0d blocks (%0d closed at full size)",
             bytes_taken, blocks_closed, full_closed);
    $display("%0d transformed bytes compared, %0d mismatches", bytes_checked, err_count);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #(4 * 3000000);
    $display("tb failed");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/bwt_pkg.sv
hw/rtl/bwt_ram.sv
hw/rtl/bwt_suffix_cmp.sv
hw/rtl/bwt_block_encoder.sv
dv/tb.sv
